/* sv/apq_pkg.sv */
// Shared types and constants for the arm position qualifier.
// Used by apq_arm and by the top level; depends on nothing else.
`timescale 1ns / 1ps

package apq_pkg;

    localparam int SENSORS_PER_ARM = 5;
    localparam int DRIVE_BITS      = 12;
    localparam int COUNT_BITS      = 11;
    localparam int POS_BITS        = 3;
    localparam int ARMS            = 3;

    // Run modes.
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_SUCC   = 2'd1;
    localparam logic [1:0] MODE_FREE   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_RUN_MODE  = 2'd0;
    localparam logic [1:0] REG_LEFT_THR  = 2'd1;
    localparam logic [1:0] REG_SIDE_THR  = 2'd2;
    localparam logic [1:0] REG_LAP_THR   = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [COUNT_BITS-1:0] LEFT_THR_RST = COUNT_BITS'(1500);
    localparam logic [COUNT_BITS-1:0] SIDE_THR_RST = COUNT_BITS'(750);
    localparam logic [COUNT_BITS-1:0] LAP_THR_RST  = COUNT_BITS'(1250);

    // Per-request control shared by all arms.
    typedef struct packed {
        logic link;
        logic clear;
        logic succ;
        logic lap_mode;
    } arm_ctrl_t;

    // Per-arm contribution to one result.
    typedef struct packed {
        logic                  wr;
        logic [DRIVE_BITS-1:0] drive;
        logic [POS_BITS-1:0]   pos;
        logic                  changed;
        logic                  lap;
    } arm_res_t;

endpackage

/* sv/apq_arm.sv */
// One arm: persistence counters, position tracking, stop flag and saved drive.
// Depends on apq_pkg.
`timescale 1ns / 1ps

module apq_arm (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                is_left,
    input  apq_pkg::arm_ctrl_t                  ctrl,
    input  logic [apq_pkg::SENSORS_PER_ARM-1:0] sensors,
    input  logic [apq_pkg::DRIVE_BITS-1:0]      drive_now,
    input  logic [apq_pkg::COUNT_BITS-1:0]      pos_thr,
    input  logic [apq_pkg::COUNT_BITS-1:0]      lap_thr,
    output apq_pkg::arm_res_t                   res
);

    logic [apq_pkg::COUNT_BITS-1:0] cnt_reg  [apq_pkg::SENSORS_PER_ARM];
    logic [apq_pkg::COUNT_BITS-1:0] cnt_next [apq_pkg::SENSORS_PER_ARM];
    logic [apq_pkg::POS_BITS-1:0]   pos_reg, pos_next;
    logic [apq_pkg::POS_BITS-1:0]   last_reg, last_next;
    logic                           stop_reg, stop_next;
    logic [apq_pkg::DRIVE_BITS-1:0] saved_reg, saved_next;
    logic [apq_pkg::DRIVE_BITS-1:0] drv;
    logic                           wr;
    logic                           changed;
    logic                           lap;
    logic                           found;

    function automatic logic [apq_pkg::COUNT_BITS-1:0] sat_inc(
        input logic [apq_pkg::COUNT_BITS-1:0] c
    );
        return (&c) ? c : c + 1'b1;
    endfunction

    // Next state of the arm for the request in the input register.
    always_comb begin
        for (int k = 0; k < apq_pkg::SENSORS_PER_ARM; k++) begin
            cnt_next[k] = cnt_reg[k];
        end
        pos_next   = pos_reg;
        last_next  = last_reg;
        stop_next  = stop_reg;
        saved_next = saved_reg;
        drv        = drive_now;
        wr         = 1'b0;
        changed    = 1'b0;
        lap        = 1'b0;
        found      = 1'b0;

        if (ctrl.link) begin
            if (ctrl.clear) begin
                for (int k = 0; k < apq_pkg::SENSORS_PER_ARM; k++) begin
                    cnt_next[k] = '0;
                end
            end

            if (ctrl.lap_mode) begin
                // Lap counting on the first sensor: a long gap, then a long hit.
                if (pos_reg == apq_pkg::POS_BITS'(0)) begin
                    cnt_next[0] = sensors[0] ? '0 : sat_inc(cnt_next[0]);
                    if (cnt_next[0] >= lap_thr) begin
                        pos_next    = apq_pkg::POS_BITS'(1);
                        cnt_next[0] = '0;
                    end
                end else if (pos_reg == apq_pkg::POS_BITS'(1)) begin
                    cnt_next[0] = sensors[0] ? sat_inc(cnt_next[0]) : '0;
                    if (cnt_next[0] >= lap_thr) begin
                        cnt_next[0] = '0;
                        pos_next    = apq_pkg::POS_BITS'(0);
                        lap         = 1'b1;
                        changed     = 1'b1;
                    end
                end
            end else begin
                // In successive mode, a stopped wheel that is driven again gets saved and zeroed.
                if (ctrl.succ && stop_reg && (drive_now != '0)) begin
                    saved_next = drive_now;
                    drv        = '0;
                    wr         = 1'b1;
                end

                // Persistence counting.
                if (is_left) begin
                    for (int s = 0; s < apq_pkg::SENSORS_PER_ARM; s++) begin
                        cnt_next[s] = sensors[s] ? sat_inc(cnt_next[s]) : '0;
                    end
                end else begin
                    for (int s = 0; s < apq_pkg::SENSORS_PER_ARM; s++) begin
                        if (!found && !sensors[s]) begin
                            cnt_next[s] = sat_inc(cnt_next[s]);
                            found       = 1'b1;
                        end
                    end
                end

                // Scan from the highest position down. Once one qualifies the
                // counters are cleared, so lower ones only follow on a zero
                // threshold.
                for (int s = apq_pkg::SENSORS_PER_ARM - 1; s >= 0; s--) begin
                    if (cnt_next[s] >= pos_thr) begin
                        for (int k = 0; k < apq_pkg::SENSORS_PER_ARM; k++) begin
                            cnt_next[k] = '0;
                        end
                        pos_next = apq_pkg::POS_BITS'(s);
                        if (last_next != apq_pkg::POS_BITS'(s)) begin
                            if (s == 0) begin
                                saved_next = ctrl.succ ? drv : '0;
                                drv        = '0;
                                wr         = 1'b1;
                                stop_next  = 1'b1;
                            end else if (stop_next) begin
                                if (ctrl.succ) begin
                                    drv = saved_next;
                                    wr  = 1'b1;
                                end
                                stop_next = 1'b0;
                            end
                            last_next = apq_pkg::POS_BITS'(s);
                            changed   = 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign res.wr      = wr;
    assign res.drive   = wr ? drv : '0;
    assign res.pos     = pos_next;
    assign res.changed = changed;
    assign res.lap     = lap;

    // State update when the request moves on to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < apq_pkg::SENSORS_PER_ARM; k++) begin
                cnt_reg[k] <= '0;
            end
            pos_reg   <= '0;
            last_reg  <= '0;
            stop_reg  <= 1'b0;
            saved_reg <= '0;
        end else if (en) begin
            for (int k = 0; k < apq_pkg::SENSORS_PER_ARM; k++) begin
                cnt_reg[k] <= cnt_next[k];
            end
            pos_reg   <= pos_next;
            last_reg  <= last_next;
            stop_reg  <= stop_next;
            saved_reg <= saved_next;
        end
    end

endmodule

/* sv/arm_position_qualifier_with_stop.sv */
// Top level of the arm position qualifier: stream ports, configuration
// registers, input and result registers. Depends on apq_pkg and apq_arm.
`timescale 1ns / 1ps

// One request is one sensor tick for all three arms. The block accepts a
// request in every cycle while it is not stalled and returns exactly one
// result per request: the request is held in an input register, the three
// arm units work on it in one pass, and the answer lands in a result
// register. Back-pressure on the result side stalls the input register, and
// the input side keeps accepting as long as the input register can move on.
// Configuration writes are taken in any cycle and should be made while no
// request is in flight.

module arm_position_qualifier_with_stop (
    input  logic        aclk,
    input  logic        aresetn,
    // Input requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    // From bit 0: link_ready, clear_window, left_sensors[5], middle_sensors[5],
    // right_sensors[5], left_drive_now[12], middle_drive_now[12],
    // right_drive_now[12], zero fill.
    input  logic [55:0] s_tdata,
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0: drive_write_mask[3], left_drive_new[12], middle_drive_new[12],
    // right_drive_new[12], left_position[3], middle_position[3],
    // right_position[3], data_changed, lap_arm[2], zero fill.
    output logic [55:0] m_tdata,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [10:0] cfg_data
);

    localparam int SB = apq_pkg::SENSORS_PER_ARM;
    localparam int DB = apq_pkg::DRIVE_BITS;

    logic [1:0]                     run_mode_reg;
    logic [apq_pkg::COUNT_BITS-1:0] left_thr_reg;
    logic [apq_pkg::COUNT_BITS-1:0] side_thr_reg;
    logic [apq_pkg::COUNT_BITS-1:0] lap_thr_reg;

    logic        in_valid_reg;
    logic [55:0] in_data_reg;
    logic        out_valid_reg;
    logic [55:0] out_data_reg;
    logic        advance;

    apq_pkg::arm_ctrl_t ctrl;
    apq_pkg::arm_res_t  res [apq_pkg::ARMS];
    logic [1:0]         lap_arm;
    logic [55:0]        result;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_mode_reg <= apq_pkg::MODE_NORMAL;
            left_thr_reg <= apq_pkg::LEFT_THR_RST;
            side_thr_reg <= apq_pkg::SIDE_THR_RST;
            lap_thr_reg  <= apq_pkg::LAP_THR_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                apq_pkg::REG_RUN_MODE: run_mode_reg <= cfg_data[1:0];
                apq_pkg::REG_LEFT_THR: left_thr_reg <= cfg_data;
                apq_pkg::REG_SIDE_THR: side_thr_reg <= cfg_data;
                apq_pkg::REG_LAP_THR:  lap_thr_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake between the input and result registers.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    // Request decode shared by all arms.
    assign ctrl.link     = in_data_reg[0];
    assign ctrl.clear    = in_data_reg[1];
    assign ctrl.succ     = (run_mode_reg == apq_pkg::MODE_SUCC);
    assign ctrl.lap_mode = (run_mode_reg == apq_pkg::MODE_FREE);

    apq_arm u_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .is_left   (1'b1),
        .ctrl      (ctrl),
        .sensors   (in_data_reg[2 +: SB]),
        .drive_now (in_data_reg[2 + 3 * SB +: DB]),
        .pos_thr   (left_thr_reg),
        .lap_thr   (lap_thr_reg),
        .res       (res[0])
    );

    apq_arm u_middle (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .is_left   (1'b0),
        .ctrl      (ctrl),
        .sensors   (in_data_reg[2 + SB +: SB]),
        .drive_now (in_data_reg[2 + 3 * SB + DB +: DB]),
        .pos_thr   (side_thr_reg),
        .lap_thr   (lap_thr_reg),
        .res       (res[1])
    );

    apq_arm u_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .is_left   (1'b0),
        .ctrl      (ctrl),
        .sensors   (in_data_reg[2 + 2 * SB +: SB]),
        .drive_now (in_data_reg[2 + 3 * SB + 2 * DB +: DB]),
        .pos_thr   (side_thr_reg),
        .lap_thr   (lap_thr_reg),
        .res       (res[2])
    );

    // The rightmost arm wins when several laps end together.
    always_comb begin
        if (res[2].lap) begin
            lap_arm = 2'd3;
        end else if (res[1].lap) begin
            lap_arm = 2'd2;
        end else if (res[0].lap) begin
            lap_arm = 2'd1;
        end else begin
            lap_arm = 2'd0;
        end
    end

    // Result packing.
    always_comb begin
        result        = '0;
        result[2:0]   = {res[2].wr, res[1].wr, res[0].wr};
        result[14:3]  = res[0].drive;
        result[26:15] = res[1].drive;
        result[38:27] = res[2].drive;
        result[41:39] = res[0].pos;
        result[44:42] = res[1].pos;
        result[47:45] = res[2].pos;
        result[48]    = res[0].changed | res[1].changed | res[2].changed;
        result[50:49] = lap_arm;
    end

endmodule

/* bench/apq_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the arm position qualifier bench: follows the request, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on apq_pkg.

module apq_result_checker
    import apq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [10:0] cfg_data,
    output int unsigned results_owed,
    output int unsigned mismatches
);

    localparam int CNT_TOTAL = ARMS * SENSORS_PER_ARM;

    // One request as it sits in s_tdata; the last member is bit 0.
    typedef struct packed {
        logic [DRIVE_BITS-1:0]      right_drive;
        logic [DRIVE_BITS-1:0]      middle_drive;
        logic [DRIVE_BITS-1:0]      left_drive;
        logic [SENSORS_PER_ARM-1:0] right_sns;
        logic [SENSORS_PER_ARM-1:0] middle_sns;
        logic [SENSORS_PER_ARM-1:0] left_sns;
        logic                       clear_window;
        logic                       link_ready;
    } tick_t;

    // One result as it sits in m_tdata; the last member is bit 0.
    typedef struct packed {
        logic [1:0]            lap_arm;
        logic                  data_changed;
        logic [POS_BITS-1:0]   right_pos;
        logic [POS_BITS-1:0]   middle_pos;
        logic [POS_BITS-1:0]   left_pos;
        logic [DRIVE_BITS-1:0] right_drive;
        logic [DRIVE_BITS-1:0] middle_drive;
        logic [DRIVE_BITS-1:0] left_drive;
        logic [ARMS-1:0]       write_mask;
    } qual_result_t;

    // Shadow copy of the configuration and of the arm state.
    logic [1:0]            mode_reg;
    logic [COUNT_BITS-1:0] left_thr, side_thr, lap_thr;
    logic [COUNT_BITS-1:0] persist_cnt [CNT_TOTAL];
    logic [POS_BITS-1:0]   arm_pos [ARMS];
    logic [POS_BITS-1:0]   settled_pos [ARMS];
    logic                  stopped [ARMS];
    logic [DRIVE_BITS-1:0] parked_drive [ARMS];

    qual_result_t owed_results [$];
    qual_result_t got_result, want_result;
    int unsigned  results_seen;
    logic         took_request, gave_result;

    function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    // Advances the shadow state by one tick and returns the result it should produce.
    function automatic qual_result_t qualify_tick(tick_t t);
        qual_result_t               r;
        logic [SENSORS_PER_ARM-1:0] sns [ARMS];
        logic [DRIVE_BITS-1:0]      drv [ARMS];
        logic [COUNT_BITS-1:0]      thr;
        logic [ARMS-1:0]            mask;
        logic                       counted;
        int                         a, s, k, base;
        r = '0;
        mask = '0;
        sns[0] = t.left_sns;
        sns[1] = t.middle_sns;
        sns[2] = t.right_sns;
        drv[0] = t.left_drive;
        drv[1] = t.middle_drive;
        drv[2] = t.right_drive;
        if (t.link_ready) begin
            if (t.clear_window) begin
                foreach (persist_cnt[i]) persist_cnt[i] = '0;
            end
            if (mode_reg == MODE_FREE) begin
                // Free-way: the first sensor must stay low, then high, for a lap.
                for (a = 0; a < ARMS; a++) begin
                    base = a * SENSORS_PER_ARM;
                    if (arm_pos[a] == 0) begin
                        persist_cnt[base] = sns[a][0] ? '0 : sat_inc(persist_cnt[base]);
                        if (persist_cnt[base] >= lap_thr) begin
                            arm_pos[a] = 1;
                            persist_cnt[base] = '0;
                        end
                    end else if (arm_pos[a] == 1) begin
                        persist_cnt[base] = sns[a][0] ? sat_inc(persist_cnt[base]) : '0;
                        if (persist_cnt[base] >= lap_thr) begin
                            persist_cnt[base] = '0;
                            arm_pos[a] = 0;
                            r.lap_arm = 2'(a + 1);
                            r.data_changed = 1'b1;
                        end
                    end
                end
            end else begin
                // In successive mode a stopped wheel that is driven again is parked first.
                if (mode_reg == MODE_SUCC) begin
                    for (a = 0; a < ARMS; a++) begin
                        if (drv[a] != '0 && stopped[a]) begin
                            parked_drive[a] = drv[a];
                            drv[a] = '0;
                            mask[a] = 1'b1;
                        end
                    end
                end
                for (a = 0; a < ARMS; a++) begin
                    base = a * SENSORS_PER_ARM;
                    thr = (a == 0) ? left_thr : side_thr;
                    counted = 1'b0;
                    // Left sensors are active high and each counts; the side arms are
                    // active low and only their lowest active sensor counts.
                    for (s = 0; s < SENSORS_PER_ARM; s++) begin
                        if (a == 0) begin
                            persist_cnt[base + s] =
                                sns[a][s] ? sat_inc(persist_cnt[base + s]) : '0;
                        end else if (!counted && !sns[a][s]) begin
                            persist_cnt[base + s] = sat_inc(persist_cnt[base + s]);
                            counted = 1'b1;
                        end
                    end
                    // Scan from the highest position down; every step that qualifies acts.
                    for (s = SENSORS_PER_ARM - 1; s >= 0; s--) begin
                        if (persist_cnt[base + s] >= thr) begin
                            for (k = 0; k < SENSORS_PER_ARM; k++) persist_cnt[base + k] = '0;
                            arm_pos[a] = POS_BITS'(s);
                            if (settled_pos[a] != POS_BITS'(s)) begin
                                if (s == 0) begin
                                    parked_drive[a] = (mode_reg == MODE_SUCC) ? drv[a] : '0;
                                    drv[a] = '0;
                                    mask[a] = 1'b1;
                                    stopped[a] = 1'b1;
                                end else if (stopped[a]) begin
                                    if (mode_reg == MODE_SUCC) begin
                                        drv[a] = parked_drive[a];
                                        mask[a] = 1'b1;
                                    end
                                    stopped[a] = 1'b0;
                                end
                                settled_pos[a] = POS_BITS'(s);
                                r.data_changed = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        r.write_mask   = mask;
        r.left_drive   = mask[0] ? drv[0] : '0;
        r.middle_drive = mask[1] ? drv[1] : '0;
        r.right_drive  = mask[2] ? drv[2] : '0;
        r.left_pos     = arm_pos[0];
        r.middle_pos   = arm_pos[1];
        r.right_pos    = arm_pos[2];
        return r;
    endfunction

    task automatic report(string msg);
        if (mismatches < 100) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want) begin
            report($sformatf("result %0d %s: got %0h, expected %0h",
                             results_seen, name, got, want));
        end
    endtask

    // All three channels are sampled at the clock edge, before the block updates them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg = MODE_NORMAL;
            left_thr = LEFT_THR_RST;
            side_thr = SIDE_THR_RST;
            lap_thr  = LAP_THR_RST;
            foreach (persist_cnt[i]) persist_cnt[i] = '0;
            foreach (arm_pos[i]) begin
                arm_pos[i]      = '0;
                settled_pos[i]  = '0;
                stopped[i]      = 1'b0;
                parked_drive[i] = '0;
            end
            owed_results.delete();
            results_seen = 0;
            results_owed <= 0;
        end else begin
            took_request = 1'b0;
            gave_result  = 1'b0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_RUN_MODE: mode_reg = cfg_data[1:0];
                    REG_LEFT_THR: left_thr = cfg_data;
                    REG_SIDE_THR: side_thr = cfg_data;
                    REG_LAP_THR:  lap_thr  = cfg_data;
                endcase
            end
            if (s_tvalid && s_tready) begin
                owed_results.push_back(qualify_tick(s_tdata[52:0]));
                took_request = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                got_result = m_tdata[50:0];
                if (owed_results.size() == 0) begin
                    report($sformatf("result %0d arrived with no request waiting",
                                     results_seen));
                end else begin
                    want_result = owed_results.pop_front();
                    gave_result = 1'b1;
                    check_field("drive_write_mask", got_result.write_mask,
                                want_result.write_mask);
                    check_field("left_drive_new", got_result.left_drive,
                                want_result.left_drive);
                    check_field("middle_drive_new", got_result.middle_drive,
                                want_result.middle_drive);
                    check_field("right_drive_new", got_result.right_drive,
                                want_result.right_drive);
                    check_field("left_position", got_result.left_pos, want_result.left_pos);
                    check_field("middle_position", got_result.middle_pos,
                                want_result.middle_pos);
                    check_field("right_position", got_result.right_pos,
                                want_result.right_pos);
                    check_field("data_changed", got_result.data_changed,
                                want_result.data_changed);
                    check_field("lap_arm", got_result.lap_arm, want_result.lap_arm);
                end
                results_seen++;
            end
            results_owed <= results_owed + took_request - gave_result;
        end
    end

endmodule

/* bench/tb_arm_position_qualifier_with_stop.sv */
`timescale 1ns / 1ps
// Top of the arm position qualifier bench: clock, reset, request and configuration
// stimulus, result back-pressure and the verdict. Depends on apq_pkg,
// apq_result_checker and the block itself.

module tb_arm_position_qualifier_with_stop;
    import apq_pkg::*;

    // The unused mode code, which the block treats as normal mode.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [COUNT_BITS-1:0] THR_MAX = '1;
    localparam logic [COUNT_BITS-1:0] THR_BIG = COUNT_BITS'(300);

    typedef logic [SENSORS_PER_ARM-1:0] sensor_t;
    typedef logic [DRIVE_BITS-1:0]      drive_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr  = '0;
    logic [10:0] cfg_data  = '0;

    int unsigned results_owed;
    int unsigned mismatches;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    always #5 aclk = ~aclk;

    arm_position_qualifier_with_stop dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    apq_result_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .results_owed (results_owed),
        .mismatches   (mismatches)
    );

    // Offers one request after a random gap and returns at the edge that takes it.
    task automatic send_tick(input logic link, input logic clr,
                             input sensor_t ls, input sensor_t ms, input sensor_t rs,
                             input drive_t ld, input drive_t md, input drive_t rd);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, rd, md, ld, rs, ms, ls, clr, link};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering and waits until every request has produced its result.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Registers are only rewritten once the block has gone quiet.
    task automatic configure(input logic [1:0] mode, input logic [COUNT_BITS-1:0] left_thr,
                             input logic [COUNT_BITS-1:0] side_thr,
                             input logic [COUNT_BITS-1:0] lap_thr);
        drain();
        write_reg(REG_RUN_MODE, {9'd0, mode});
        write_reg(REG_LEFT_THR, left_thr);
        write_reg(REG_SIDE_THR, side_thr);
        write_reg(REG_LAP_THR, lap_thr);
        cfg_valid <= 1'b0;
    endtask

    function automatic drive_t pick_drive();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3:       return '1;
            default: return drive_t'($urandom);
        endcase
    endfunction

    function automatic sensor_t active_high_pattern();
        case ($urandom_range(0, 4))
            0, 1, 2: return sensor_t'(1) << $urandom_range(0, SENSORS_PER_ARM - 1);
            3:       return sensor_t'($urandom);
            default: return '0;
        endcase
    endfunction

    // Active-low pattern whose lowest active sensor is chosen, the ones above it random.
    function automatic sensor_t active_low_pattern();
        sensor_t v;
        int      p, b;
        if ($urandom_range(0, 6) == 0) return '1;
        p = $urandom_range(0, SENSORS_PER_ARM - 1);
        v = sensor_t'($urandom);
        for (b = 0; b <= p; b++) v[b] = (b != p);
        return v;
    endfunction

    // Sensor patterns are held for random runs so that counters reach their thresholds;
    // a few ticks carry noise, a dropped link or a window clear.
    task automatic random_ticks(input int count, input int hold_max, input bit lap_style);
        sensor_t pat [ARMS];
        sensor_t sns [ARMS];
        int      hold [ARMS];
        int      n, a;
        logic    link, clr;
        for (a = 0; a < ARMS; a++) begin
            hold[a] = 0;
            pat[a] = '0;
        end
        for (n = 0; n < count; n++) begin
            for (a = 0; a < ARMS; a++) begin
                if (hold[a] == 0) begin
                    hold[a] = $urandom_range(1, hold_max);
                    if (lap_style) pat[a] = sensor_t'($urandom);
                    else if (a == 0) pat[a] = active_high_pattern();
                    else pat[a] = active_low_pattern();
                end
                hold[a]--;
                sns[a] = pat[a];
            end
            if ($urandom_range(0, 11) == 0) begin
                for (a = 0; a < ARMS; a++) sns[a] = sensor_t'($urandom);
            end
            link = ($urandom_range(0, 19) != 0);
            clr  = ($urandom_range(0, 29) == 0);
            send_tick(link, clr, sns[0], sns[1], sns[2], pick_drive(), pick_drive(),
                      pick_drive());
        end
    endtask

    // Offers patterns for positions one, one and zero so that free-way counting can start.
    task automatic park_arms();
        configure(MODE_NORMAL, 1, 1, 1);
        send_tick(1, 0, 5'h02, 5'h1d, 5'h1e, pick_drive(), pick_drive(), pick_drive());
    endtask

    // Result side: random stalls, calm stretches, and now and then a long hold-off
    // that lets the block fill up and push back on its input.
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (taken % 400 == 150) stall = 60;
            else stall = rx_calm ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    initial begin : stimulus
        int n;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Field extremes at the reset settings: dropped link, all zero, all one.
        send_tick(0, 0, '1, '1, '1, '1, '1, '1);
        send_tick(1, 1, '0, '0, '0, '0, '0, '0);
        send_tick(1, 0, '1, '1, '1, '1, '1, '1);

        // Normal mode, immediate qualification: stop on position zero, then release.
        configure(MODE_NORMAL, 1, 1, 1);
        send_tick(1, 0, 5'h10, 5'h0f, 5'h17, 12'h111, 12'h222, 12'h333);
        send_tick(1, 0, 5'h01, 5'h1e, 5'h1e, 12'habc, 12'hfff, 12'h001);
        send_tick(1, 0, 5'h04, 5'h1b, 5'h1d, 12'h0f0, 12'h000, 12'h800);

        // Successive mode: park on stop, park a drive that comes back, then restore.
        configure(MODE_SUCC, 1, 1, 1);
        send_tick(1, 0, 5'h01, 5'h1e, 5'h1e, 12'h123, 12'h456, 12'h789);
        send_tick(1, 0, 5'h00, 5'h1f, 5'h1f, 12'h321, 12'h000, 12'hfff);
        send_tick(1, 0, 5'h08, 5'h17, 5'h0f, 12'h555, 12'h000, 12'h000);

        // Unused mode code with zero thresholds: every position qualifies in one scan.
        configure(MODE_SPARE, 0, 0, 0);
        send_tick(1, 0, 5'h00, 5'h1f, 5'h1f, 12'h7ff, 12'h001, 12'h9a5);
        send_tick(1, 1, 5'h15, 5'h0a, 5'h1f, 12'hfff, 12'hfff, 12'h000);

        // Free-way laps, several at once, one alone, and a dropped link.
        configure(MODE_FREE, 1, 1, 1);
        send_tick(1, 0, 5'h00, 5'h00, 5'h00, 12'h000, 12'h000, 12'h000);
        send_tick(1, 0, 5'h01, 5'h01, 5'h01, 12'hfff, 12'hfff, 12'hfff);
        send_tick(1, 0, 5'h00, 5'h1f, 5'h1f, 12'h000, 12'h000, 12'h000);
        send_tick(1, 0, 5'h01, 5'h00, 5'h00, 12'h000, 12'h000, 12'h000);
        send_tick(0, 1, 5'h1f, 5'h1f, 5'h1f, 12'hfff, 12'hfff, 12'hfff);

        // Free-way with arms beyond position one: those arms stay put.
        configure(MODE_NORMAL, 1, 1, 1);
        send_tick(1, 0, 5'h10, 5'h0f, 5'h0f, 12'h000, 12'h000, 12'h000);
        configure(MODE_FREE, 1, 1, THR_MAX);
        send_tick(1, 0, 5'h00, 5'h00, 5'h00, 12'h000, 12'h000, 12'h000);
        send_tick(1, 1, 5'h1f, 5'h1f, 5'h1f, 12'hfff, 12'hfff, 12'hfff);

        // Random phases across modes and threshold settings.
        configure(MODE_NORMAL, 4, 3, 5);
        random_ticks(150, 8, 1'b0);
        configure(MODE_SUCC, 2, 5, 3);
        random_ticks(150, 8, 1'b0);
        park_arms();
        configure(MODE_FREE, 9, 9, 3);
        random_ticks(150, 6, 1'b1);
        configure(MODE_SUCC, 1, 1, 1);
        random_ticks(100, 3, 1'b0);
        configure(MODE_NORMAL, 1, 12, 7);
        random_ticks(100, 16, 1'b0);
        park_arms();
        configure(MODE_FREE, THR_MAX, 1, 1);
        random_ticks(60, 3, 1'b1);
        configure(MODE_SPARE, 0, 0, 0);
        random_ticks(40, 4, 1'b0);

        // Large thresholds: hold steady patterns until the counters reach them.
        configure(MODE_SUCC, THR_BIG, THR_BIG, THR_BIG);
        for (n = 0; n < 320; n++) begin
            send_tick(1, 0, 5'h08, 5'h1b, 5'h1d, pick_drive(), pick_drive(), pick_drive());
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_arm_position_qualifier_with_stop OK");
        end else begin
            $display("tb_arm_position_qualifier_with_stop NOT OK");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("tb_arm_position_qualifier_with_stop NOT OK");
        $finish;
    end

endmodule
